### rtl/core/dsv_pkg.sv
package dsv_pkg;

	localparam int CHAR_W  = 8;
	localparam int POS_W   = 4;
	localparam int VAL_W   = 7;
	localparam int DIGIT_W = 4;
	localparam int OUT_W   = 8;

	localparam logic [CHAR_W-1:0] SLASH_CODE = 8'h2F;
	localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] DIGIT_NINE = 8'h39;

	// character positions within dd/mm/yyyy
	localparam logic [POS_W-1:0] POS_DAY_END    = 4'd2;
	localparam logic [POS_W-1:0] POS_SLASH_DAY  = 4'd2;
	localparam logic [POS_W-1:0] POS_SLASH_MON  = 4'd5;
	localparam logic [POS_W-1:0] POS_MON_END    = 4'd5;
	localparam logic [POS_W-1:0] POS_CENT_END   = 4'd8;
	localparam logic [POS_W-1:0] FULL_LENGTH    = 4'd10;

	localparam logic [VAL_W-1:0] MONTH_FEB = 7'd2;
	localparam logic [VAL_W-1:0] MONTH_APR = 7'd4;
	localparam logic [VAL_W-1:0] MONTH_JUN = 7'd6;
	localparam logic [VAL_W-1:0] MONTH_SEP = 7'd9;
	localparam logic [VAL_W-1:0] MONTH_NOV = 7'd11;
	localparam logic [VAL_W-1:0] MONTH_DEC = 7'd12;

	localparam logic [VAL_W-1:0] DAYS_LONG  = 7'd31;
	localparam logic [VAL_W-1:0] DAYS_SHORT = 7'd30;
	localparam logic [VAL_W-1:0] DAYS_LEAP  = 7'd29;
	localparam logic [VAL_W-1:0] DAYS_FEB   = 7'd28;

	// year kept as century digits and last two digits
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             fmt_good;
		logic [VAL_W-1:0] day;
		logic [VAL_W-1:0] month;
		logic [VAL_W-1:0] cent;
		logic [VAL_W-1:0] yy;
	} acc_t;

	localparam acc_t ACC_RESET = '{
		pos:      '0,
		fmt_good: 1'b1,
		day:      '0,
		month:    '0,
		cent:     '0,
		yy:       '0
	};

	function automatic logic [VAL_W-1:0] mul10_add(input logic [VAL_W-1:0] v,
		input logic [DIGIT_W-1:0] d);
		logic [VAL_W+3:0] sum;
		sum = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{VAL_W{1'b0}}, d};
		return sum[VAL_W-1:0];
	endfunction

endpackage

### rtl/core/date_string_validator.sv
// Checks dd/mm/yyyy date strings sent one ASCII character per input beat, with tlast
// on the final character. Each string gives exactly one output beat, on its last
// character: bit 0 of m_tdata is 1 when positions 0-1, 3-4 and 6-9 are digits,
// positions 2 and 5 are '/', and the date exists in the Gregorian calendar.
// Characters after the tenth are ignored; a string shorter than ten characters
// fails. A beat is taken every cycle but for the stall below; a character goes
// through one input register, and the result of a last character is then
// captured in the output register. Input beats stall only while the output
// register holds an untaken result and the input register holds a last character.
module date_string_validator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [dsv_pkg::CHAR_W-1:0] s_tdata,  // [7:0] char_code
	input  logic                       s_tlast,  // is_last
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [dsv_pkg::OUT_W-1:0]  m_tdata   // [0] date_valid, [7:1] zero
);
	import dsv_pkg::*;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              advance;
	logic              out_valid_q;
	logic              date_valid_q;
	logic              check_ok;
	acc_t              acc_nxt;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	dsv_field_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.char_code (char_s1),
		.is_last   (last_s1),
		.acc_nxt   (acc_nxt)
	);

	dsv_date_check u_check (
		.acc        (acc_nxt),
		.date_valid (check_ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			date_valid_q <= check_ok;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W-1){1'b0}}, date_valid_q};

endmodule

### rtl/core/dsv_field_accum.sv
module dsv_field_accum (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [dsv_pkg::CHAR_W-1:0] char_code,
	input  logic                  is_last,
	output dsv_pkg::acc_t         acc_nxt
);
	import dsv_pkg::*;

	acc_t                acc_q;
	logic                is_digit;
	logic [DIGIT_W-1:0]  digit;
	logic [CHAR_W-1:0]   offset;

	assign is_digit = (char_code >= DIGIT_ZERO) && (char_code <= DIGIT_NINE);
	assign offset   = char_code - DIGIT_ZERO;
	assign digit    = offset[DIGIT_W-1:0];

	always_comb begin
		acc_nxt = acc_q;
		if (acc_q.pos < FULL_LENGTH) begin
			if (acc_q.pos == POS_SLASH_DAY || acc_q.pos == POS_SLASH_MON) begin
				if (char_code != SLASH_CODE) begin
					acc_nxt.fmt_good = 1'b0;
				end
			end else if (is_digit) begin
				if (acc_q.pos < POS_DAY_END) begin
					acc_nxt.day = mul10_add(acc_q.day, digit);
				end else if (acc_q.pos < POS_MON_END) begin
					acc_nxt.month = mul10_add(acc_q.month, digit);
				end else if (acc_q.pos < POS_CENT_END) begin
					acc_nxt.cent = mul10_add(acc_q.cent, digit);
				end else begin
					acc_nxt.yy = mul10_add(acc_q.yy, digit);
				end
			end else begin
				acc_nxt.fmt_good = 1'b0;
			end
			acc_nxt.pos = acc_q.pos + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= ACC_RESET;
		end else if (step) begin
			acc_q <= is_last ? ACC_RESET : acc_nxt;
		end
	end

endmodule

### rtl/core/dsv_date_check.sv
module dsv_date_check (
	input  dsv_pkg::acc_t acc,
	output logic          date_valid
);
	import dsv_pkg::*;

	logic             leap;
	logic [VAL_W-1:0] top;
	logic             month_ok;
	logic             day_ok;

	// leap: yy divisible by 4 and not zero, or yy zero and century divisible by 4
	assign leap = (acc.yy == '0) ? (acc.cent[1:0] == 2'b00) : (acc.yy[1:0] == 2'b00);

	always_comb begin
		case (acc.month)
			MONTH_FEB: top = leap ? DAYS_LEAP : DAYS_FEB;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: top = DAYS_SHORT;
			default: top = DAYS_LONG;
		endcase
	end

	assign month_ok   = (acc.month != '0) && (acc.month <= MONTH_DEC);
	assign day_ok     = (acc.day != '0) && (acc.day <= top);
	assign date_valid = acc.fmt_good && (acc.pos == FULL_LENGTH) && month_ok && day_ok;

endmodule

### tb/date_string_checker.sv
module date_string_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [dsv_pkg::CHAR_W-1:0] s_tdata,  // [7:0] char_code
	input  logic                       s_tlast,  // is_last
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [dsv_pkg::OUT_W-1:0]  m_tdata,  // [0] date_valid, [7:1] zero
	output int                         fail_count,
	output int                         pending_results,
	output int                         results_checked,
	output int                         valid_dates
);

	import dsv_pkg::*;

	logic [3:0]  char_pos  = '0;
	logic        fmt_ok    = 1'b1;
	logic [6:0]  day_acc   = '0;
	logic [6:0]  month_acc = '0;
	logic [13:0] year_acc  = '0;

	logic [OUT_W-1:0] verdict_q [$];

	int n_fail    = 0;
	int n_checked = 0;
	int n_valid   = 0;

	initial begin
		fail_count      = 0;
		pending_results = 0;
		results_checked = 0;
		valid_dates     = 0;
	end

	function automatic logic date_exists(input logic [6:0] d, input logic [6:0] m,
		input logic [13:0] y);
		int top;
		logic leap;
		leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
		if (m < 1 || m > 12)
			return 1'b0;
		if (m == 2)
			top = leap ? 29 : 28;
		else if (m == 4 || m == 6 || m == 9 || m == 11)
			top = 30;
		else
			top = 31;
		return (d >= 1) && (d <= top);
	endfunction

	task automatic take_char(input logic [CHAR_W-1:0] c, input logic last);
		logic [3:0] digit;
		logic ok;
		if (char_pos < FULL_LENGTH) begin
			if (char_pos == POS_SLASH_DAY || char_pos == POS_SLASH_MON) begin
				if (c != SLASH_CODE)
					fmt_ok = 1'b0;
			end else if (c >= DIGIT_ZERO && c <= DIGIT_NINE) begin
				digit = 4'(c - DIGIT_ZERO);
				if (char_pos < POS_DAY_END)
					day_acc = 7'(day_acc * 10 + digit);
				else if (char_pos < POS_MON_END)
					month_acc = 7'(month_acc * 10 + digit);
				else
					year_acc = 14'(year_acc * 10 + digit);
			end else begin
				fmt_ok = 1'b0;
			end
			char_pos = char_pos + 1'b1;
		end
		if (last) begin
			ok = fmt_ok && (char_pos == FULL_LENGTH) && date_exists(day_acc, month_acc, year_acc);
			verdict_q.push_back({{(OUT_W-1){1'b0}}, ok});
			char_pos  = '0;
			fmt_ok    = 1'b1;
			day_acc   = '0;
			month_acc = '0;
			year_acc  = '0;
		end
	endtask

	always @(posedge clk) begin
		logic [OUT_W-1:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("unexpected result beat: m_tdata=%h", m_tdata);
				end else begin
					want = verdict_q.pop_front();
					n_checked++;
					if (m_tdata[0])
						n_valid++;
					if (m_tdata !== want) begin
						n_fail++;
						if (n_fail <= 10)
							$display("result %0d mismatch: date_valid exp %b got %b, pad exp %h got %h",
								n_checked, want[0], m_tdata[0], want[OUT_W-1:1],
								m_tdata[OUT_W-1:1]);
					end
				end
			end
			if (s_tvalid && s_tready)
				take_char(s_tdata, s_tlast);
			fail_count      <= n_fail;
			pending_results <= verdict_q.size();
			results_checked <= n_checked;
			valid_dates     <= n_valid;
		end
	end

endmodule

### tb/tb_date_string_validator.sv
module tb_date_string_validator;

	import dsv_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [CHAR_W-1:0]  s_tdata = '0;   // [7:0] char_code
	logic               s_tlast = 1'b0; // is_last
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;        // [0] date_valid, [7:1] zero

	int fail_count;
	int pending_results;
	int results_checked;
	int valid_dates;

	idle_mode_t idle_mode = IDLE_NONE;
	logic [CHAR_W-1:0] str_buf [0:15];
	int str_len;
	int sent_chars = 0;
	int sent_strings = 0;

	always #5 clk = ~clk;

	date_string_validator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	date_string_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.fail_count      (fail_count),
		.pending_results (pending_results),
		.results_checked (results_checked),
		.valid_dates     (valid_dates)
	);

	always @(negedge clk) begin
		if (idle_mode == IDLE_RECV)
			m_tready <= ($urandom_range(0, 99) >= 65);
		else if (idle_mode == IDLE_BOTH)
			m_tready <= ($urandom_range(0, 99) >= 8);
		else
			m_tready <= 1'b1;
	end

	function automatic logic sender_gap();
		if (idle_mode == IDLE_SEND)
			return $urandom_range(0, 99) < 65;
		if (idle_mode == IDLE_BOTH)
			return $urandom_range(0, 99) < 8;
		return 1'b0;
	endfunction

	// called and returns at a falling edge, tvalid left high
	task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
		while (sender_gap()) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_chars++;
		@(negedge clk);
	endtask

	task automatic send_string();
		int i;
		for (i = 0; i < str_len; i++)
			send_char(str_buf[i], i == str_len - 1);
		sent_strings++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			str_buf[i] = s[i];
		str_len = s.len();
		send_string();
	endtask

	task automatic put_date(input int d, input int m, input int y);
		str_buf[0] = 8'(DIGIT_ZERO + (d / 10) % 10);
		str_buf[1] = 8'(DIGIT_ZERO + d % 10);
		str_buf[2] = SLASH_CODE;
		str_buf[3] = 8'(DIGIT_ZERO + (m / 10) % 10);
		str_buf[4] = 8'(DIGIT_ZERO + m % 10);
		str_buf[5] = SLASH_CODE;
		str_buf[6] = 8'(DIGIT_ZERO + (y / 1000) % 10);
		str_buf[7] = 8'(DIGIT_ZERO + (y / 100) % 10);
		str_buf[8] = 8'(DIGIT_ZERO + (y / 10) % 10);
		str_buf[9] = 8'(DIGIT_ZERO + y % 10);
		str_len = 10;
	endtask

	task automatic make_random_string();
		int kind, d, m, y, k, i;
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			d = $urandom_range(0, 32);
			m = $urandom_range(0, 13);
			// lean on february around its last days
			if ($urandom_range(0, 3) == 0) begin
				m = 2;
				d = $urandom_range(27, 30);
			end
			if ($urandom_range(0, 19) == 0) begin
				d = $urandom_range(0, 99);
				m = $urandom_range(0, 99);
			end
			case ($urandom_range(0, 3))
				0: y = $urandom_range(0, 9999);
				1: y = 4 * $urandom_range(0, 2499);
				2: y = 100 * $urandom_range(0, 99);
				default: y = 400 * $urandom_range(0, 24);
			endcase
			put_date(d, m, y);
			if (kind >= 70) begin
				case ($urandom_range(0, 2))
					0: str_buf[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
					1: str_len = $urandom_range(1, 9);
					default: begin
						k = $urandom_range(1, 5);
						for (i = 0; i < k; i++)
							str_buf[10 + i] = 8'($urandom_range(0, 255));
						str_len = 10 + k;
					end
				endcase
			end
		end else begin
			str_len = $urandom_range(1, 14);
			for (i = 0; i < str_len; i++) begin
				if ($urandom_range(0, 2) == 0)
					str_buf[i] = 8'($urandom_range(0, 255));
				else if ($urandom_range(0, 3) == 0)
					str_buf[i] = SLASH_CODE;
				else
					str_buf[i] = 8'(DIGIT_ZERO + $urandom_range(0, 9));
			end
		end
	endtask

	task automatic run_phase(input idle_mode_t mode, input int n_chars);
		int stop_at;
		idle_mode = mode;
		stop_at = sent_chars + n_chars;
		while (sent_chars < stop_at) begin
			make_random_string();
			send_string();
		end
	endtask

	initial begin
		#3000000;
		$display("tb_date_string_validator failed");
		$finish;
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// year zero counts as leap
		send_text("29/02/0000");
		// thirty-day month overflow, trailing character ignored
		send_text("31/04/1900z");
		// lone last character at the top code
		str_buf[0] = 8'hFF;
		str_len = 1;
		send_string();
		// short string starting at the bottom code
		str_buf[0] = 8'h00;
		str_buf[1] = SLASH_CODE;
		str_len = 2;
		send_string();

		run_phase(IDLE_NONE, 280);

		// hold off until the block has drained
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_results != 0)
			@(negedge clk);

		run_phase(IDLE_SEND, 280);
		run_phase(IDLE_RECV, 280);
		run_phase(IDLE_BOTH, 280);

		s_tvalid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d strings (%0d characters) across four idling patterns",
			sent_strings, sent_chars);
		$display("checked %0d result beats, %0d of them valid dates",
			results_checked, valid_dates);
		if (fail_count == 0 && pending_results == 0) begin
			$display("tb_date_string_validator passed");
		end else begin
			$display("tb_date_string_validator failed");
		end
		$finish;
	end

endmodule
